// ----- hdl/consistent_hash_replica_select_assert.svh -----
// Assertion macros for the replica selector top level.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef CONSISTENT_HASH_REPLICA_SELECT_ASSERT_SVH
`define CONSISTENT_HASH_REPLICA_SELECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CHRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CHRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/chrs_pkg.sv -----
// Shared types and constants of the consistent-hash replica selector.
// No dependencies; used by chrs_hash, the top level and the bench.
package chrs_pkg;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_KEY    = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_TRUNC = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_OVF   = 2'd3
	} status_t;

	// Register select bit (paddr[2])
	localparam logic REG_ATT_LIMIT    = 1'b0;
	localparam logic REG_WORKER_TOTAL = 1'b1;
	localparam logic [7:0] ATT_LIMIT_RST = 8'd100;

	// Murmur3 x86_32 constants
	localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2 = 32'h1b873593;
	localparam logic [31:0] MM_C3 = 32'h85ebca6b;
	localparam logic [31:0] MM_C4 = 32'hc2b2ae35;
	localparam logic [31:0] MM_C5 = 32'he6546b64;
	localparam logic [31:0] SIGN_FLIP = 32'h80000000;

	typedef enum logic [3:0] {
		HS_IDLE, HS_FETCH, HS_TAKE, HS_MUL1, HS_MUL2, HS_ROUND,
		HS_FIN0, HS_FIN1, HS_FIN2, HS_FIN3, HS_DONE
	} hash_state_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INS_MOD, S_BS_RD, S_BS_CMP, S_INS_RD, S_INS_EQ, S_INS_CHK,
		S_SH_RD, S_SH_WR, S_INS_PUT, S_LK_START, S_LK_HASH, S_LK_WAIT,
		S_LK_RD, S_LK_OWN, S_EMIT
	} top_state_t;

	typedef struct packed {
		logic       start;
		logic [7:0] attempt;
	} hash_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] hash;
	} hash_rsp_t;

endpackage

// ----- hdl/chrs_ring.sv -----
// Ring point storage: hash and owner memories, one write and one read port.
// Read data registered. Depends on nothing.
module chrs_ring #(
	parameter int RING_DEPTH = 1024,
	parameter int RAW = 10
) (
	input  logic           clk,
	input  logic [RAW-1:0] raddr,
	output logic [31:0]    rd_hash,
	output logic [7:0]     rd_owner,
	input  logic           we,
	input  logic [RAW-1:0] waddr,
	input  logic [31:0]    wr_hash,
	input  logic [7:0]     wr_owner
);

	logic [31:0] hash_mem [RING_DEPTH];
	logic [7:0]  own_mem  [RING_DEPTH];

	// hash memory
	always_ff @(posedge clk) begin
		if (we) begin
			hash_mem[waddr] <= wr_hash;
		end
		rd_hash <= hash_mem[raddr];
	end

	// owner memory
	always_ff @(posedge clk) begin
		if (we) begin
			own_mem[waddr] <= wr_owner;
		end
		rd_owner <= own_mem[raddr];
	end

endmodule

// ----- hdl/chrs_hash.sv -----
// Key buffer memory and byte-serial Murmur3 x86_32 (seed 0) engine.
// Hashes the key followed by the attempt number; depends on chrs_pkg.
module chrs_hash #(
	parameter int MAX_KEY_BYTES = 256,
	parameter int KAW = 8,
	parameter int KLW = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_we,
	input  logic [KAW-1:0]      key_waddr,
	input  logic [7:0]          key_wdata,
	input  logic [KLW-1:0]      key_len,
	input  chrs_pkg::hash_req_t req,
	output chrs_pkg::hash_rsp_t rsp
);

	localparam int BW = $clog2(MAX_KEY_BYTES + 5);

	chrs_pkg::hash_state_t state_q, state_d;
	logic [7:0]  key_mem [MAX_KEY_BYTES];
	logic [7:0]  rd_q;
	logic [BW-1:0] bi_q;
	logic [7:0]  attempt_q;
	logic [31:0] k_q, t_q, h_q;
	logic [BW-1:0] len_w, klen_w;
	logic        last_byte, blk_end;
	logic [7:0]  byte_v;
	logic [31:0] x_round, x_fin0, y_fin2;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		rotl = (x << r) | (x >> (32 - r));
	endfunction

	// key buffer: written by the intake, read by the byte index
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		rd_q <= key_mem[bi_q[KAW-1:0]];
	end

	// message byte and block position
	always_comb begin
		klen_w    = BW'(key_len);
		len_w     = klen_w + BW'(4);
		last_byte = (bi_q == len_w - BW'(1));
		blk_end   = (bi_q[1:0] == 2'd3);
		if (bi_q < klen_w) begin
			byte_v = rd_q;
		end else if (bi_q == klen_w) begin
			byte_v = attempt_q;
		end else begin
			byte_v = 8'd0;
		end
		x_round = rotl(h_q ^ t_q, 13);
		x_fin0  = h_q ^ 32'(len_w);
		y_fin2  = h_q ^ (h_q >> 13);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chrs_pkg::HS_IDLE:  if (req.start) state_d = chrs_pkg::HS_FETCH;
			chrs_pkg::HS_FETCH: state_d = chrs_pkg::HS_TAKE;
			chrs_pkg::HS_TAKE: begin
				if (blk_end || last_byte) state_d = chrs_pkg::HS_MUL1;
				else state_d = chrs_pkg::HS_FETCH;
			end
			chrs_pkg::HS_MUL1:  state_d = chrs_pkg::HS_MUL2;
			chrs_pkg::HS_MUL2:  state_d = chrs_pkg::HS_ROUND;
			chrs_pkg::HS_ROUND: begin
				if (last_byte) state_d = chrs_pkg::HS_FIN0;
				else state_d = chrs_pkg::HS_FETCH;
			end
			chrs_pkg::HS_FIN0:  state_d = chrs_pkg::HS_FIN1;
			chrs_pkg::HS_FIN1:  state_d = chrs_pkg::HS_FIN2;
			chrs_pkg::HS_FIN2:  state_d = chrs_pkg::HS_FIN3;
			chrs_pkg::HS_FIN3:  state_d = chrs_pkg::HS_DONE;
			chrs_pkg::HS_DONE:  state_d = chrs_pkg::HS_IDLE;
			default:            state_d = chrs_pkg::HS_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		rsp.busy = (state_q != chrs_pkg::HS_IDLE);
		rsp.done = (state_q == chrs_pkg::HS_DONE);
		rsp.hash = h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chrs_pkg::HS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: one byte at a time, at most one multiply per stage
	always_ff @(posedge clk) begin
		unique case (state_q)
			chrs_pkg::HS_IDLE: begin
				if (req.start) begin
					bi_q      <= '0;
					h_q       <= '0;
					attempt_q <= req.attempt;
				end
			end
			chrs_pkg::HS_TAKE: begin
				if (bi_q[1:0] == 2'd0) k_q <= {24'd0, byte_v};
				else k_q <= k_q | ({24'd0, byte_v} << {bi_q[1:0], 3'b000});
				if (!(blk_end || last_byte)) bi_q <= bi_q + BW'(1);
			end
			chrs_pkg::HS_MUL1: t_q <= 32'(k_q * chrs_pkg::MM_C1);
			chrs_pkg::HS_MUL2: t_q <= 32'(rotl(t_q, 15) * chrs_pkg::MM_C2);
			chrs_pkg::HS_ROUND: begin
				if (blk_end) h_q <= 32'((x_round << 2) + x_round + chrs_pkg::MM_C5);
				else h_q <= h_q ^ t_q;
				if (!last_byte) bi_q <= bi_q + BW'(1);
			end
			chrs_pkg::HS_FIN0: h_q <= x_fin0 ^ (x_fin0 >> 16);
			chrs_pkg::HS_FIN1: h_q <= 32'(h_q * chrs_pkg::MM_C3);
			chrs_pkg::HS_FIN2: h_q <= 32'(y_fin2 * chrs_pkg::MM_C4);
			chrs_pkg::HS_FIN3: h_q <= h_q ^ (h_q >> 16);
			default: ;
		endcase
	end

endmodule

// ----- hdl/consistent_hash_replica_select.sv -----
// Top level of the consistent-hash replica selector: intake, ring sequencer,
// lookup loop and result stage. Depends on chrs_pkg, chrs_ring, chrs_hash.
//
// Input beats (s_*): tuser carries the kind (clear ring, insert point, key
// byte); tlast marks the final key byte and starts a lookup. Clear beats and
// non-final key bytes are absorbed in the idle state. An insert runs a binary
// search and then shifts the points above it up one entry at a time through
// the ring memory's single read port.
// Each lookup attempt hashes an L-byte key byte-serially off the key memory
// port, then binary-searches the ring, up to the attempt limit. Results
// (m_*) then leave one per cycle while the receiver is ready: tdata the
// worker, tuser {status, found}, tlast on the final one. s_tready is high
// only between operations.
// A result sits in the output register while the next input beat is taken;
// when the receiver stalls, the block waits with the beat held.
// Reset empties the ring, the key buffer and the flags, sets the attempt limit
// to 100 and worker_total to 0; no memory clearing pass is needed.
// Registers (APB, 32-bit): 0x0 attempt limit, 0x4 worker_total.
module consistent_hash_replica_select #(
	parameter int RING_DEPTH    = 1024,
	parameter int MAX_KEY_BYTES = 256,
	parameter int MAX_REPLICAS  = 8,
	parameter int WORKER_SLOTS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: point_hash[31:0], worker_number[39:32], key_byte[47:40],
	// want_count[51:48], zero fill
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,   // kind[1:0]
	input  logic        s_tlast,   // key_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // chosen_worker[7:0]
	output logic [2:0]  m_tuser,   // found[0], status[2:1]
	output logic        m_tlast,   // last_result
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int FW  = $clog2(RING_DEPTH + 1);
	localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
	localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int CW  = $clog2(MAX_REPLICAS + 1);
	localparam int PIW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;

	chrs_pkg::top_state_t state_q, state_d;

	// config registers
	logic [7:0] max_att_q;
	logic [8:0] wt_q;

	// control state
	logic [FW-1:0]  fill_q;
	logic           ring_ovf_q, trunc_q;
	logic [KLW-1:0] key_len_q;
	logic [CW-1:0]  picked_q, count_q, emit_q;
	logic           out_valid_q;

	// payload
	logic [31:0]    new_hash_q, tgt_q;
	logic [7:0]     new_own_q, attempt_q;
	logic           mode_ins_q;
	logic [FW-1:0]  lo_q, hi_q, idx_q;
	logic [7:0]     picked_list_q [MAX_REPLICAS];
	chrs_pkg::status_t status_q;
	logic [7:0]     out_worker_q;
	logic           out_found_q, out_last_q;
	chrs_pkg::status_t out_status_q;

	// intake fields
	chrs_pkg::kind_t in_kind;
	logic [31:0]    in_hash;
	logic [7:0]     in_worker, in_byte;
	logic [3:0]     in_want;
	logic           in_acc, cfg_wr;

	// datapath helpers
	logic [FW:0]    mid_sum;
	logic [FW-1:0]  mid, lk_pos;
	logic           go_right, fresh, lk_more, out_free, emit_last, lk_end;
	logic [CW:0]    pick_n;
	logic [9:0]     cnt_w;
	logic [7:0]     emit_worker;

	// ring and hash connections
	logic [RAW-1:0] ring_raddr, ring_waddr;
	logic           ring_we;
	logic [31:0]    ring_wh, ring_rh;
	logic [7:0]     ring_wo, ring_ro;
	logic           key_we;
	chrs_pkg::hash_req_t hash_req;
	chrs_pkg::hash_rsp_t hash_rsp;

	function automatic logic [31:0] sk(input logic [31:0] h);
		sk = h ^ chrs_pkg::SIGN_FLIP;
	endfunction

	chrs_ring #(.RING_DEPTH(RING_DEPTH), .RAW(RAW)) u_ring (
		.clk      (clk),
		.raddr    (ring_raddr),
		.rd_hash  (ring_rh),
		.rd_owner (ring_ro),
		.we       (ring_we),
		.waddr    (ring_waddr),
		.wr_hash  (ring_wh),
		.wr_owner (ring_wo)
	);

	chrs_hash #(.MAX_KEY_BYTES(MAX_KEY_BYTES), .KAW(KAW), .KLW(KLW)) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_we    (key_we),
		.key_waddr (key_len_q[KAW-1:0]),
		.key_wdata (in_byte),
		.key_len   (key_len_q),
		.req       (hash_req),
		.rsp       (hash_rsp)
	);

	// APB port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr[2])
			chrs_pkg::REG_ATT_LIMIT:    prdata = {24'd0, max_att_q};
			chrs_pkg::REG_WORKER_TOTAL: prdata = {23'd0, wt_q};
			default:                    prdata = '0;
		endcase
	end

	// unpack intake beat and helper terms
	always_comb begin
		in_kind   = chrs_pkg::kind_t'(s_tuser);
		in_hash   = s_tdata[31:0];
		in_worker = s_tdata[39:32];
		in_byte   = s_tdata[47:40];
		in_want   = s_tdata[51:48];
		in_acc    = s_tvalid && s_tready;

		mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
		mid      = mid_sum[FW:1];
		go_right = mode_ins_q ? (sk(ring_rh) < tgt_q) : (sk(ring_rh) <= tgt_q);
		lk_pos   = (lo_q == fill_q) ? '0 : lo_q;

		// replica count: min(want, worker_total, MAX_REPLICAS)
		cnt_w = {6'd0, in_want};
		if ({1'b0, wt_q} < cnt_w) cnt_w = {1'b0, wt_q};
		if (cnt_w > 10'(MAX_REPLICAS)) cnt_w = 10'(MAX_REPLICAS);

		fresh = 1'b1;
		for (int j = 0; j < MAX_REPLICAS; j++) begin
			if ((CW'(j) < picked_q) && (picked_list_q[j] == ring_ro)) fresh = 1'b0;
		end
		pick_n  = {1'b0, picked_q} + {{CW{1'b0}}, fresh};
		lk_more = (pick_n < {1'b0, count_q}) && (attempt_q < max_att_q);

		out_free    = !out_valid_q || m_tready;
		emit_last   = (picked_q == '0) || (emit_q == picked_q - CW'(1));
		emit_worker = (picked_q == '0) ? 8'd0 : picked_list_q[emit_q[PIW-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chrs_pkg::S_IDLE: begin
				if (in_acc) begin
					priority if (in_kind == chrs_pkg::KIND_INSERT) state_d = chrs_pkg::S_INS_MOD;
					else if (in_kind == chrs_pkg::KIND_KEY && s_tlast) state_d = chrs_pkg::S_LK_START;
					else state_d = chrs_pkg::S_IDLE;
				end
			end
			chrs_pkg::S_INS_MOD: begin
				if (!({24'd0, new_own_q} >= WORKER_SLOTS)) state_d = chrs_pkg::S_BS_RD;
			end
			chrs_pkg::S_BS_RD: begin
				if (lo_q < hi_q) state_d = chrs_pkg::S_BS_CMP;
				else if (mode_ins_q) state_d = chrs_pkg::S_INS_RD;
				else state_d = chrs_pkg::S_LK_RD;
			end
			chrs_pkg::S_BS_CMP: state_d = chrs_pkg::S_BS_RD;
			chrs_pkg::S_INS_RD: begin
				if (lo_q < fill_q) state_d = chrs_pkg::S_INS_EQ;
				else state_d = chrs_pkg::S_INS_CHK;
			end
			chrs_pkg::S_INS_EQ: begin
				if (ring_rh == new_hash_q) state_d = chrs_pkg::S_IDLE;
				else state_d = chrs_pkg::S_INS_CHK;
			end
			chrs_pkg::S_INS_CHK: begin
				priority if (fill_q >= FW'(RING_DEPTH)) state_d = chrs_pkg::S_IDLE;
				else if (fill_q > lo_q) state_d = chrs_pkg::S_SH_RD;
				else state_d = chrs_pkg::S_INS_PUT;
			end
			chrs_pkg::S_SH_RD: state_d = chrs_pkg::S_SH_WR;
			chrs_pkg::S_SH_WR: begin
				if (idx_q == lo_q) state_d = chrs_pkg::S_INS_PUT;
				else state_d = chrs_pkg::S_SH_RD;
			end
			chrs_pkg::S_INS_PUT: state_d = chrs_pkg::S_IDLE;
			chrs_pkg::S_LK_START: begin
				if (fill_q == '0 || count_q == '0 || max_att_q == 8'd0)
					state_d = chrs_pkg::S_EMIT;
				else state_d = chrs_pkg::S_LK_HASH;
			end
			chrs_pkg::S_LK_HASH: state_d = chrs_pkg::S_LK_WAIT;
			chrs_pkg::S_LK_WAIT: if (hash_rsp.done) state_d = chrs_pkg::S_BS_RD;
			chrs_pkg::S_LK_RD:   state_d = chrs_pkg::S_LK_OWN;
			chrs_pkg::S_LK_OWN: begin
				if (lk_more) state_d = chrs_pkg::S_LK_HASH;
				else state_d = chrs_pkg::S_EMIT;
			end
			chrs_pkg::S_EMIT: if (out_free && emit_last) state_d = chrs_pkg::S_IDLE;
			default: state_d = chrs_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready         = 1'b0;
		ring_raddr       = mid[RAW-1:0];
		ring_we          = 1'b0;
		ring_waddr       = lo_q[RAW-1:0];
		ring_wh          = new_hash_q;
		ring_wo          = new_own_q;
		key_we           = 1'b0;
		hash_req.start   = 1'b0;
		hash_req.attempt = attempt_q;
		lk_end           = 1'b0;
		unique case (state_q)
			chrs_pkg::S_IDLE: begin
				s_tready = 1'b1;
				key_we   = in_acc && (in_kind == chrs_pkg::KIND_KEY) &&
					(key_len_q < KLW'(MAX_KEY_BYTES));
			end
			chrs_pkg::S_INS_RD: ring_raddr = lo_q[RAW-1:0];
			chrs_pkg::S_SH_RD:  ring_raddr = idx_q[RAW-1:0];
			chrs_pkg::S_SH_WR: begin
				ring_we    = 1'b1;
				ring_waddr = RAW'(idx_q + FW'(1));
				ring_wh    = ring_rh;
				ring_wo    = ring_ro;
			end
			chrs_pkg::S_INS_PUT: ring_we = 1'b1;
			chrs_pkg::S_LK_START: begin
				lk_end = (fill_q == '0 || count_q == '0 || max_att_q == 8'd0);
			end
			chrs_pkg::S_LK_HASH: hash_req.start = 1'b1;
			chrs_pkg::S_LK_RD:   ring_raddr = lk_pos[RAW-1:0];
			chrs_pkg::S_LK_OWN:  lk_end = !lk_more;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chrs_pkg::S_IDLE;
			max_att_q   <= chrs_pkg::ATT_LIMIT_RST;
			wt_q        <= '0;
			fill_q      <= '0;
			ring_ovf_q  <= 1'b0;
			trunc_q     <= 1'b0;
			key_len_q   <= '0;
			picked_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == chrs_pkg::REG_ATT_LIMIT) max_att_q <= pwdata[7:0];
			if (cfg_wr && paddr[2] == chrs_pkg::REG_WORKER_TOTAL) wt_q <= pwdata[8:0];

			if (in_acc && in_kind == chrs_pkg::KIND_CLEAR) begin
				fill_q     <= '0;
				ring_ovf_q <= 1'b0;
			end
			if (in_acc && in_kind == chrs_pkg::KIND_KEY) begin
				if (key_we) key_len_q <= key_len_q + KLW'(1);
				else trunc_q <= 1'b1;
				if (s_tlast) begin
					count_q  <= CW'(cnt_w);
					picked_q <= '0;
				end
			end
			if (state_q == chrs_pkg::S_INS_CHK && fill_q >= FW'(RING_DEPTH)) ring_ovf_q <= 1'b1;
			if (state_q == chrs_pkg::S_INS_PUT) fill_q <= fill_q + FW'(1);
			if (state_q == chrs_pkg::S_LK_OWN && fresh) picked_q <= pick_n[CW-1:0];
			if (lk_end) begin
				key_len_q <= '0;
				trunc_q   <= 1'b0;
			end

			// output register
			if (state_q == chrs_pkg::S_EMIT && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			chrs_pkg::S_IDLE: begin
				if (in_acc && in_kind == chrs_pkg::KIND_INSERT) begin
					new_hash_q <= in_hash;
					new_own_q  <= in_worker;
					tgt_q      <= sk(in_hash);
					mode_ins_q <= 1'b1;
					lo_q       <= '0;
					hi_q       <= fill_q;
				end
			end
			chrs_pkg::S_INS_MOD: begin
				if ({24'd0, new_own_q} >= WORKER_SLOTS) new_own_q <= new_own_q - 8'(WORKER_SLOTS);
			end
			chrs_pkg::S_BS_CMP: begin
				if (go_right) lo_q <= FW'(mid + FW'(1));
				else hi_q <= mid;
			end
			chrs_pkg::S_INS_CHK: idx_q <= fill_q - FW'(1);
			chrs_pkg::S_SH_WR:   idx_q <= idx_q - FW'(1);
			chrs_pkg::S_LK_START: begin
				attempt_q <= 8'd1;
				emit_q    <= '0;
				priority if (fill_q == '0) status_q <= chrs_pkg::STAT_EMPTY;
				else if (ring_ovf_q) status_q <= chrs_pkg::STAT_OVF;
				else if (trunc_q) status_q <= chrs_pkg::STAT_TRUNC;
				else status_q <= chrs_pkg::STAT_OK;
			end
			chrs_pkg::S_LK_WAIT: begin
				if (hash_rsp.done) begin
					tgt_q      <= sk(hash_rsp.hash);
					mode_ins_q <= 1'b0;
					lo_q       <= '0;
					hi_q       <= fill_q;
				end
			end
			chrs_pkg::S_LK_OWN: begin
				if (fresh) picked_list_q[picked_q[PIW-1:0]] <= ring_ro;
				attempt_q <= attempt_q + 8'd1;
			end
			chrs_pkg::S_EMIT: begin
				if (out_free) begin
					out_worker_q <= emit_worker;
					out_found_q  <= (picked_q != '0);
					out_status_q <= status_q;
					out_last_q   <= emit_last;
					emit_q       <= emit_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_worker_q;
	assign m_tuser  = {out_status_q, out_found_q};
	assign m_tlast  = out_last_q;

	`include "consistent_hash_replica_select_assert.svh"

	`CHRS_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FW'(RING_DEPTH))
	`CHRS_ASSERT_IMP(a_hash_idle_on_start, state_q == chrs_pkg::S_LK_HASH, !hash_rsp.busy)
	`CHRS_ASSERT_IMP(a_picked_cap, 1'b1, picked_q <= count_q)
	`CHRS_ASSERT_NEXT(a_insert_grows, state_q == chrs_pkg::S_INS_PUT, fill_q == FW'($past(fill_q) + FW'(1)))

endmodule

// ----- bench/consistent_hash_replica_select_tb.sv -----
// Self-checking bench for consistent_hash_replica_select: ring upkeep, key streaming,
// replica lookups over the stream ports and register writes over APB.
// Depends on chrs_pkg and the RTL top level only.
module consistent_hash_replica_select_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_CAP     = 1024;
	localparam int KEY_CAP      = 256;
	localparam int REPLICA_CAP  = 8;
	localparam int STALL_LIMIT  = 500000;
	localparam int SETTLE_CYCLES = 2300;

	typedef struct {
		bit [7:0] worker;
		bit       found;
		chrs_pkg::status_t status;
		bit       last;
	} replica_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	bit [31:0] ring_hash_q[$];
	bit [7:0]  ring_owner_q[$];
	bit [7:0]  key_q[$];
	bit        key_trunc;
	bit        ring_ovf;
	int        attempts_cfg = 100;
	int        workers_cfg = 0;
	replica_t  replica_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int fail_count = 0;
	int beats_in = 0;
	int beats_out = 0;
	int lookups = 0;
	int stall_cnt = 0;

	consistent_hash_replica_select dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic bit [31:0] rotl(bit [31:0] x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic bit [31:0] mix_block(bit [31:0] k);
		k = k * chrs_pkg::MM_C1;
		k = rotl(k, 15);
		return k * chrs_pkg::MM_C2;
	endfunction

	function automatic bit [31:0] murmur3(bit [7:0] msg[$]);
		int nb;
		int len;
		bit [31:0] h;
		bit [31:0] k;
		len = msg.size();
		nb = len / 4;
		h = '0;
		for (int b = 0; b < nb; b++) begin
			k = {msg[4*b+3], msg[4*b+2], msg[4*b+1], msg[4*b]};
			h ^= mix_block(k);
			h = rotl(h, 13);
			h = h * 5 + chrs_pkg::MM_C5;
		end
		k = '0;
		if (len % 4 >= 3) k ^= 32'(msg[4*nb+2]) << 16;
		if (len % 4 >= 2) k ^= 32'(msg[4*nb+1]) << 8;
		if (len % 4 >= 1) begin
			k ^= 32'(msg[4*nb]);
			h ^= mix_block(k);
		end
		h ^= 32'(len);
		h ^= h >> 16;
		h = h * chrs_pkg::MM_C3;
		h ^= h >> 13;
		h = h * chrs_pkg::MM_C4;
		h ^= h >> 16;
		return h;
	endfunction

	// owner of first point strictly above h, wrapping to the lowest point
	function automatic bit [7:0] ring_successor(bit [31:0] h);
		foreach (ring_hash_q[i])
			if ($signed(ring_hash_q[i]) > $signed(h)) return ring_owner_q[i];
		return ring_owner_q[0];
	endfunction

	function automatic void ring_add(bit [31:0] h, bit [7:0] owner);
		int pos;
		pos = 0;
		while (pos < ring_hash_q.size() && $signed(ring_hash_q[pos]) < $signed(h)) pos++;
		if (pos < ring_hash_q.size() && ring_hash_q[pos] == h) return;
		if (ring_hash_q.size() >= RING_CAP) begin
			ring_ovf = 1'b1;
			return;
		end
		ring_hash_q.insert(pos, h);
		ring_owner_q.insert(pos, owner);
	endfunction

	function automatic void pick_replicas(int want);
		chrs_pkg::status_t st;
		int cnt;
		bit [7:0] picked[$];
		bit [7:0] msg[$];
		bit [7:0] w;
		replica_t r;
		if (ring_hash_q.size() == 0) st = chrs_pkg::STAT_EMPTY;
		else if (ring_ovf) st = chrs_pkg::STAT_OVF;
		else if (key_trunc) st = chrs_pkg::STAT_TRUNC;
		else st = chrs_pkg::STAT_OK;
		cnt = want;
		if (cnt > workers_cfg) cnt = workers_cfg;
		if (cnt > REPLICA_CAP) cnt = REPLICA_CAP;
		if (ring_hash_q.size() != 0) begin
			for (int a = 1; a <= attempts_cfg && picked.size() < cnt; a++) begin
				msg = key_q;
				for (int j = 0; j < 4; j++) msg = {msg, 8'(a >> (8 * j))};
				w = ring_successor(murmur3(msg));
				if (!(w inside {picked})) picked = {picked, w};
			end
		end
		key_q.delete();
		key_trunc = 1'b0;
		lookups++;
		if (picked.size() == 0) begin
			r = '{worker: 8'd0, found: 1'b0, status: st, last: 1'b1};
			replica_q = {replica_q, r};
		end
		foreach (picked[i]) begin
			r = '{worker: picked[i], found: 1'b1, status: st, last: i == picked.size() - 1};
			replica_q = {replica_q, r};
		end
	endfunction

	function automatic void apply_beat(chrs_pkg::kind_t kind, bit [31:0] h, bit [7:0] wn,
			bit [7:0] kb, bit last, bit [3:0] want);
		case (kind)
			chrs_pkg::KIND_CLEAR: begin
				ring_hash_q.delete();
				ring_owner_q.delete();
				ring_ovf = 1'b0;
			end
			chrs_pkg::KIND_INSERT: ring_add(h, wn);
			chrs_pkg::KIND_KEY: begin
				if (key_q.size() < KEY_CAP) key_q = {key_q, kb};
				else key_trunc = 1'b1;
				if (last) pick_replicas(want);
			end
			default: ;
		endcase
	endfunction

	// ---------------- drivers ----------------
	task automatic send_beat(chrs_pkg::kind_t kind, bit [31:0] h = '0, bit [7:0] wn = '0,
			bit [7:0] kb = '0, bit last = 1'b0, bit [3:0] want = '0);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tlast = last;
		s_tdata = {4'd0, want, kb, wn, h};
		do @(posedge clk); while (!s_tready);
		beats_in++;
		apply_beat(kind, h, wn, kb, last, want);
		@(negedge clk);
	endtask

	task automatic send_key(int len, bit [3:0] want);
		for (int i = 0; i < len; i++)
			send_beat(chrs_pkg::KIND_KEY, $urandom, 8'($urandom), 8'($urandom),
				i == len - 1, want);
	endtask

	// waits until every expected result is out and the block has settled
	task automatic drain();
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		while (replica_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(logic idx, int val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == chrs_pkg::REG_ATT_LIMIT) attempts_cfg = val & 8'hFF;
		else workers_cfg = val & 9'h1FF;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_regs(int attempts, int workers);
		drain();
		reg_write(chrs_pkg::REG_ATT_LIMIT, attempts);
		reg_write(chrs_pkg::REG_WORKER_TOTAL, workers);
	endtask

	// ---------------- receiver and checker ----------------
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		replica_t e;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt = 0;
		else stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("FAIL consistent_hash_replica_select");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			beats_out++;
			if (replica_q.size() == 0) begin
				$error("result beat with none expected: worker %0d", m_tdata);
				fail_count++;
			end else begin
				e = replica_q.pop_front();
				if (m_tdata !== e.worker) begin
					$error("chosen_worker expected %0d got %0d", e.worker, m_tdata);
					fail_count++;
				end
				if (m_tuser[0] !== e.found) begin
					$error("found expected %0d got %0d", e.found, m_tuser[0]);
					fail_count++;
				end
				if (m_tuser[2:1] !== e.status) begin
					$error("status expected %0d got %0d", e.status, m_tuser[2:1]);
					fail_count++;
				end
				if (m_tlast !== e.last) begin
					$error("last_result expected %0d got %0d", e.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// ---------------- tests ----------------
	task automatic test_empty_ring();
		send_key(1, 4'd3);
		send_beat(chrs_pkg::KIND_NONE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 4'hF);
	endtask

	task automatic test_basic_ring();
		set_regs(255, 256);
		send_beat(chrs_pkg::KIND_INSERT, 32'h8000_0000, 8'd0);
		send_beat(chrs_pkg::KIND_INSERT, 32'h7FFF_FFFF, 8'd255);
		send_beat(chrs_pkg::KIND_INSERT, 32'h0000_0000, 8'd7);
		send_beat(chrs_pkg::KIND_INSERT, 32'h0000_0000, 8'd9);   // same hash, dropped
		send_beat(chrs_pkg::KIND_INSERT, 32'hFFFF_FFFF, 8'd42, 8'd0, 1'b1);
		send_key(2, 4'd15);                             // above replica cap
		send_key(1, 4'd0);                              // nothing requested
		send_key(3, 4'd8);
	endtask

	task automatic test_register_extremes();
		set_regs(1, 0);
		send_key(2, 4'd5);                              // cap to zero workers
		set_regs(1, 4);
		send_key(1, 4'd4);                              // single attempt
		set_regs(0, 4);
		send_key(1, 4'd4);                              // no attempts
		set_regs(100, 2);
		send_key(4, 4'd8);
	endtask

	task automatic build_ring(int points);
		bit [7:0] wn;
		send_beat(chrs_pkg::KIND_CLEAR);
		for (int i = 0; i < points; i++) begin
			wn = ($urandom_range(1) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
			send_beat(chrs_pkg::KIND_INSERT, $urandom, wn, 8'($urandom),
				1'($urandom_range(1)));
		end
	endtask

	task automatic test_random_phase(int items, int attempts, int workers);
		int start;
		set_regs(attempts, workers);
		start = beats_in;
		build_ring($urandom_range(2, 12));
		while (beats_in - start < items) begin
			case ($urandom_range(0, 9))
				0: build_ring($urandom_range(1, 10));
				1: send_beat(chrs_pkg::KIND_INSERT, $urandom, 8'($urandom));
				2: send_beat(chrs_pkg::KIND_NONE, $urandom, 8'($urandom), 8'($urandom),
					1'($urandom_range(1)));
				default: send_key($urandom_range(1, 8), 4'($urandom));
			endcase
		end
	endtask

	task automatic test_output_backpressure();
		set_regs(100, 8);
		send_beat(chrs_pkg::KIND_CLEAR);
		for (int i = 0; i < 8; i++)
			send_beat(chrs_pkg::KIND_INSERT, 32'h9000_0000 + 32'(i) * 32'h1E00_0000,
				8'(10 + i));
		hold_cycles = 5000;
		for (int i = 0; i < 6; i++) send_key(1, 4'd8);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_ring();
		test_basic_ring();
		test_register_extremes();
		send_idle_pct = 25;
		recv_idle_pct = 70;
		test_random_phase(55, 100, 6);
		send_idle_pct = 70;
		recv_idle_pct = 25;
		test_random_phase(55, 255, 256);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_phase(55, 40, 3);
		test_output_backpressure();
		drain();
		$display("covered %0d input beats, %0d lookups, %0d result beats", beats_in, lookups,
			beats_out);
		$display("incl. empty ring, duplicate points, register extremes, long output stall");
		if (fail_count == 0) $display("PASS consistent_hash_replica_select");
		else $display("FAIL consistent_hash_replica_select");
		$finish;
	end

endmodule

// ----- consistent_hash_replica_select.f -----
+incdir+hdl
hdl/chrs_pkg.sv
hdl/chrs_ring.sv
hdl/chrs_hash.sv
hdl/consistent_hash_replica_select.sv
bench/consistent_hash_replica_select_tb.sv
